// ----- sv/coc_pkg.sv -----
// ---------------------------------------------------------------------------
// Current offset calibration package
// Payload types, register indexes and status codes shared by the calibration
// block and its channel lanes.
// ---------------------------------------------------------------------------
package coc_pkg;

  // Width of one raw ADC reading and of one averaged offset.
  localparam int ADC_BITS = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SENSING_MODE  = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_TARGET = 2'd1;
  localparam logic [1:0] CFG_UPPER_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_LOWER_LIMIT   = 2'd3;

  // Calibration status codes.
  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_PASS = 2'd1;
  localparam logic [1:0] STATUS_FAIL = 2'd2;

  // One input transaction: a raw sample of every channel.
  typedef struct packed {
    logic [ADC_BITS-1:0] sample_a;
    logic [ADC_BITS-1:0] sample_b;
    logic [ADC_BITS-1:0] sample_c;
    logic [ADC_BITS-1:0] sample_shunt;
  } coc_in_t;

  // One output transaction: status and averaged offsets.
  typedef struct packed {
    logic [1:0]          status;
    logic [ADC_BITS-1:0] offset_a;
    logic [ADC_BITS-1:0] offset_b;
    logic [ADC_BITS-1:0] offset_c;
    logic [ADC_BITS-1:0] offset_shunt;
  } coc_out_t;

  // Step commands from the sequencer to every channel lane.
  typedef struct packed {
    logic load;      // take a new sample into the lane
    logic acc_step;  // one bit of the serial accumulation
    logic div_step;  // one quotient bit of the restoring division
  } coc_lane_ctrl_t;

endpackage

// ----- sv/current_offset_calibration.sv -----
// A sample that does not complete the run is accumulated bit-serially in ST_ACC, then
// reported from ST_EMIT; the completing sample also passes ST_DIV (one quotient bit per
// cycle) and ST_JUDGE, and once finished a sample goes straight to ST_EMIT, which holds
// while the result register is stalled. One transaction is in work at a time; the next is
// accepted on return to idle, even while the last result waits. Reset clears the
// sequencer and calibration state at once; the payload registers are not reset.
// ---------------------------------------------------------------------------
// Current offset calibration
// Averages raw ADC current samples per channel, divides each sum by the
// sample count on completion and judges the offsets against a window.
// ---------------------------------------------------------------------------
module current_offset_calibration #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Sample channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  coc_pkg::coc_in_t  in_data_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output coc_pkg::coc_out_t out_data_o,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import coc_pkg::*;

  localparam int SUM_W = ADC_BITS + COUNT_BITS;
  localparam int CNT_W = $clog2(SUM_W);
  localparam int TGT_W = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_JUDGE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  // Configuration registers.
  logic                  mode_q;
  logic [15:0]           target_q;
  logic [ADC_BITS-1:0]   upper_q;
  logic [ADC_BITS-1:0]   lower_q;

  // Sequencer and calibration state.
  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] taken_q, taken_d;
  logic                  cmpl_q, cmpl_d;
  logic                  finished_q, finished_d;
  logic [1:0]            fin_status_q, fin_status_d;
  logic                  fin_mode_q, fin_mode_d;
  logic                  out_valid_q, out_valid_d;
  coc_out_t              out_q, out_d;

  coc_lane_ctrl_t        lane_ctrl;
  logic [ADC_BITS-1:0]   q_a, q_b, q_c, q_sh;

  logic                  in_accept;
  logic                  out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      target_q <= 16'd1024;
      upper_q  <= ADC_BITS'(2248);
      lower_q  <= ADC_BITS'(1848);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SENSING_MODE:  mode_q   <= cfg_data_i[0];
        CFG_SAMPLE_TARGET: target_q <= cfg_data_i;
        CFG_UPPER_LIMIT:   upper_q  <= cfg_data_i[ADC_BITS-1:0];
        CFG_LOWER_LIMIT:   lower_q  <= cfg_data_i[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective target: zero counts as one, large values saturate to the
  // counter range. The run completes when the new count reaches it.
  logic [COUNT_BITS:0] count_next;
  logic [TGT_W-1:0]    tgt_raw, tgt_max, tgt_eff;
  logic                complete;
  always_comb begin
    count_next = {1'b0, taken_q} + {{COUNT_BITS{1'b0}}, 1'b1};
    tgt_raw    = TGT_W'(target_q);
    tgt_max    = TGT_W'({COUNT_BITS{1'b1}});
    if (tgt_raw == '0) begin
      tgt_eff = TGT_W'(1);
    end else if (tgt_raw > tgt_max) begin
      tgt_eff = tgt_max;
    end else begin
      tgt_eff = tgt_raw;
    end
    complete = TGT_W'(count_next) >= tgt_eff;
  end

  // Window check on the averaged offsets of the judged channels.
  logic bad_abc, bad_sh;
  assign bad_abc = (q_a > upper_q) || (q_a < lower_q) ||
                   (q_b > upper_q) || (q_b < lower_q) ||
                   (q_c > upper_q) || (q_c < lower_q);
  assign bad_sh  = (q_sh > upper_q) || (q_sh < lower_q);

  // Sequencer: accumulate bit by bit, divide on completion, then report; once finished, report the held result.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    taken_d      = taken_q;
    cmpl_d       = cmpl_q;
    finished_d   = finished_q;
    fin_status_d = fin_status_q;
    fin_mode_d   = fin_mode_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    lane_ctrl    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (finished_q) begin
            state_d = ST_EMIT;
          end else begin
            lane_ctrl.load = 1'b1;
            taken_d        = count_next[COUNT_BITS-1:0];
            cmpl_d         = complete;
            cnt_d          = '0;
            state_d        = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        lane_ctrl.acc_step = 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          cnt_d   = '0;
          state_d = cmpl_q ? ST_DIV : ST_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        if (cnt_q == CNT_W'(ADC_BITS - 1)) begin
          cnt_d   = '0;
          state_d = ST_JUDGE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_JUDGE: begin
        finished_d   = 1'b1;
        fin_mode_d   = mode_q;
        fin_status_d = (mode_q ? bad_sh : bad_abc) ? STATUS_FAIL : STATUS_PASS;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = finished_q ? fin_status_q : STATUS_BUSY;
          out_d.offset_a     = (finished_q && !fin_mode_q) ? q_a : '0;
          out_d.offset_b     = (finished_q && !fin_mode_q) ? q_b : '0;
          out_d.offset_c     = (finished_q && !fin_mode_q) ? q_c : '0;
          out_d.offset_shunt = (finished_q && fin_mode_q) ? q_sh : '0;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      taken_q      <= '0;
      cmpl_q       <= 1'b0;
      finished_q   <= 1'b0;
      fin_status_q <= STATUS_BUSY;
      fin_mode_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      taken_q      <= taken_d;
      cmpl_q       <= cmpl_d;
      finished_q   <= finished_d;
      fin_status_q <= fin_status_d;
      fin_mode_q   <= fin_mode_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One lane per channel; all four accumulate in both modes.
  coc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (in_data_i.sample_a),
    .divisor_i  (taken_q),
    .quotient_o (q_a)
  );

  coc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (in_data_i.sample_b),
    .divisor_i  (taken_q),
    .quotient_o (q_b)
  );

  coc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_c (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (in_data_i.sample_c),
    .divisor_i  (taken_q),
    .quotient_o (q_c)
  );

  coc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_sh (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .sample_i   (in_data_i.sample_shunt),
    .divisor_i  (taken_q),
    .quotient_o (q_sh)
  );

endmodule

// ----- sv/coc_lane.sv -----
// ---------------------------------------------------------------------------
// Calibration channel lane
// Holds one channel's running sum, adds a sample into it one bit per cycle
// and divides the sum by the sample count one quotient bit per cycle.
// ---------------------------------------------------------------------------
module coc_lane #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  coc_pkg::coc_lane_ctrl_t       ctrl_i,
  input  logic [coc_pkg::ADC_BITS-1:0]  sample_i,
  input  logic [COUNT_BITS-1:0]         divisor_i,
  output logic [coc_pkg::ADC_BITS-1:0]  quotient_o
);
  import coc_pkg::*;

  localparam int SUM_W = ADC_BITS + COUNT_BITS;

  logic [ADC_BITS-1:0] smp_q, smp_d;
  logic                carry_q, carry_d;
  logic [SUM_W-1:0]    sum_q, sum_d;

  // Serial full adder on the low bits of the rotating sum and sample.
  logic add_bit;
  logic add_carry;
  assign add_bit   = sum_q[0] ^ smp_q[0] ^ carry_q;
  assign add_carry = (sum_q[0] & smp_q[0]) | (carry_q & (sum_q[0] ^ smp_q[0]));

  // Restoring division step: trial subtract of the divisor from the
  // partial remainder extended by the next dividend bit.
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS+1:0] diff;
  logic                  q_bit;
  logic [COUNT_BITS-1:0] rem_next;
  assign trial    = sum_q[SUM_W-1:ADC_BITS-1];
  assign diff     = {1'b0, trial} - {2'b00, divisor_i};
  assign q_bit    = ~diff[COUNT_BITS+1];
  assign rem_next = q_bit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

  // Next state of the lane registers.
  always_comb begin
    smp_d   = smp_q;
    carry_d = carry_q;
    sum_d   = sum_q;
    if (ctrl_i.load) begin
      smp_d   = sample_i;
      carry_d = 1'b0;
    end else if (ctrl_i.acc_step) begin
      smp_d   = {1'b0, smp_q[ADC_BITS-1:1]};
      carry_d = add_carry;
      sum_d   = {add_bit, sum_q[SUM_W-1:1]};
    end else if (ctrl_i.div_step) begin
      sum_d   = {rem_next, sum_q[ADC_BITS-2:0], q_bit};
    end
  end

  // The sum is calibration state and clears on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Sample shift register and carry hold payload only.
  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    carry_q <= carry_d;
  end

  // After the division the quotient sits in the low bits of the sum.
  assign quotient_o = sum_q[ADC_BITS-1:0];

endmodule

// ----- tb/current_offset_calibration_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Current offset calibration testbench
// Drives raw sample transactions and register writes into the calibration
// block. Each result transaction is checked field by field against a model
// of the running sums, the truncating average and the offset window judgment.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module current_offset_calibration_test;
  import coc_pkg::*;

  // One pending register write.
  typedef struct packed {
    logic [1:0]  idx;
    logic [15:0] val;
  } reg_write_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  coc_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  coc_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Register copies as the block should hold them.
  logic        mode_q;
  logic [15:0] target_q;
  logic [11:0] upper_q;
  logic [11:0] lower_q;

  // Calibration state as the block should hold it.
  logic [15:0] taken_cnt;
  logic [27:0] acc_a;
  logic [27:0] acc_b;
  logic [27:0] acc_c;
  logic [27:0] acc_shunt;
  logic        calib_done;
  logic [1:0]  held_status;

  coc_out_t   offset_reports[$];
  reg_write_t write_list[$];
  int unsigned mismatches;
  int unsigned results_seen;
  bit          steady;

  current_offset_calibration u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit out_of_window(input logic [27:0] v);
    return (v > upper_q) || (v < lower_q);
  endfunction

  // Adds one sample to the running sums and queues the result it causes.
  task automatic accumulate_sample(input coc_in_t s);
    coc_out_t    r;
    logic [16:0] goal;
    logic [16:0] count_next;
    bit          bad;
    if (!calib_done) begin
      goal = (target_q == 16'd0) ? 17'd1 : {1'b0, target_q};
      acc_a     += s.sample_a;
      acc_b     += s.sample_b;
      acc_c     += s.sample_c;
      acc_shunt += s.sample_shunt;
      count_next = taken_cnt + 17'd1;
      taken_cnt  = count_next[15:0];
      // The count has reached the target: average and judge the channels.
      if (count_next >= goal) begin
        acc_a     = acc_a / count_next;
        acc_b     = acc_b / count_next;
        acc_c     = acc_c / count_next;
        acc_shunt = acc_shunt / count_next;
        if (mode_q == 1'b0) begin
          bad = out_of_window(acc_a) || out_of_window(acc_b) || out_of_window(acc_c);
          acc_shunt = '0;
        end else begin
          bad = out_of_window(acc_shunt);
          acc_a = '0;
          acc_b = '0;
          acc_c = '0;
        end
        held_status = bad ? STATUS_FAIL : STATUS_PASS;
        calib_done  = 1'b1;
      end
    end
    r = '0;
    if (calib_done) begin
      r.status       = held_status;
      r.offset_a     = acc_a[11:0];
      r.offset_b     = acc_b[11:0];
      r.offset_c     = acc_c[11:0];
      r.offset_shunt = acc_shunt[11:0];
    end else begin
      r.status = STATUS_BUSY;
    end
    offset_reports.push_back(r);
  endtask

  // A reading spread around a center, clamped to the ADC range.
  function automatic logic [11:0] near(input int center, input int spread);
    int v;
    v = center - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic coc_in_t draw_sample(input int center, input int spread);
    coc_in_t s;
    s.sample_a     = near(center, spread);
    s.sample_b     = near(center, spread);
    s.sample_c     = near(center, spread);
    s.sample_shunt = near(center, spread);
    return s;
  endfunction

  function automatic coc_in_t pack_sample(input logic [11:0] a, input logic [11:0] b,
                                          input logic [11:0] c, input logic [11:0] sh);
    coc_in_t s;
    s.sample_a     = a;
    s.sample_b     = b;
    s.sample_c     = c;
    s.sample_shunt = sh;
    return s;
  endfunction

  function automatic void queue_write(input logic [1:0] idx, input logic [15:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    write_list.push_back(w);
  endfunction

  // Drives all queued register writes back to back.
  task automatic flush_writes();
    reg_write_t w;
    while (write_list.size() != 0) begin
      w = write_list.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.val;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (w.idx)
        CFG_SENSING_MODE:  mode_q   = w.val[0];
        CFG_SAMPLE_TARGET: target_q = w.val;
        CFG_UPPER_LIMIT:   upper_q  = w.val[11:0];
        CFG_LOWER_LIMIT:   lower_q  = w.val[11:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one sample transaction. Valid stays high between back-to-back items.
  task automatic send_sample(input coc_in_t s);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_sample(s);
  endtask

  // Holds off the sender until every queued result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (offset_reports.size() != 0);
  endtask

  // Result side: random stalls, then check each accepted transaction.
  initial begin
    int unsigned hold;
    coc_out_t    want;
    coc_out_t    got;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      got = out_data_o;
      results_seen++;
      if (offset_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no sample outstanding",
                                  results_seen));
      end else begin
        want = offset_reports.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, got.status, want.status));
        if (got.offset_a !== want.offset_a)
          report_mismatch($sformatf("result %0d offset_a got %0d want %0d",
                                    results_seen, got.offset_a, want.offset_a));
        if (got.offset_b !== want.offset_b)
          report_mismatch($sformatf("result %0d offset_b got %0d want %0d",
                                    results_seen, got.offset_b, want.offset_b));
        if (got.offset_c !== want.offset_c)
          report_mismatch($sformatf("result %0d offset_c got %0d want %0d",
                                    results_seen, got.offset_c, want.offset_c));
        if (got.offset_shunt !== want.offset_shunt)
          report_mismatch($sformatf("result %0d offset_shunt got %0d want %0d",
                                    results_seen, got.offset_shunt, want.offset_shunt));
      end
    end
  end

  // Field extremes and bit patterns under the reset register values.
  task automatic test_reset_defaults();
    steady = 1'b0;
    send_sample(pack_sample(12'h000, 12'h000, 12'h000, 12'h000));
    send_sample(pack_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    send_sample(pack_sample(12'hAAA, 12'h555, 12'hAAA, 12'h555));
    send_sample(pack_sample(12'h555, 12'hAAA, 12'h555, 12'hAAA));
    send_sample(pack_sample(12'h000, 12'hFFF, 12'h000, 12'hFFF));
    send_sample(pack_sample(12'hFFF, 12'h000, 12'hFFF, 12'h000));
    send_sample(pack_sample(12'd800, 12'd2048, 12'd3300, 12'd1));
    send_sample(pack_sample(12'd1, 12'd2, 12'd3, 12'd4));
    wait_idle();
  endtask

  // Register extremes, an inverted window and a mode change mid-run.
  task automatic test_register_extremes();
    queue_write(CFG_SENSING_MODE, 16'd1);
    queue_write(CFG_SAMPLE_TARGET, 16'hFFFF);
    queue_write(CFG_UPPER_LIMIT, 16'd4095);
    queue_write(CFG_LOWER_LIMIT, 16'd0);
    flush_writes();
    repeat (4) send_sample(draw_sample(2048, 4095));
    wait_idle();
    // A target of one written and withdrawn before the next sample has no effect.
    queue_write(CFG_SAMPLE_TARGET, 16'd1);
    queue_write(CFG_SAMPLE_TARGET, 16'hFFFF);
    queue_write(CFG_UPPER_LIMIT, 16'd0);
    queue_write(CFG_LOWER_LIMIT, 16'd4095);
    queue_write(CFG_SENSING_MODE, 16'd0);
    flush_writes();
    repeat (4) send_sample(draw_sample(2048, 4095));
    wait_idle();
  endtask

  // Long accumulation across several register settings, never reaching the target.
  task automatic test_random_accumulation();
    int center;
    int spread;
    for (int seg = 0; seg < 6; seg++) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      // Unused upper data bits carry noise; the registers keep only their width.
      queue_write(CFG_SENSING_MODE, 16'($urandom_range(0, 65535)));
      queue_write(CFG_SAMPLE_TARGET, ($urandom_range(0, 2) == 0) ? 16'hFFFF :
                  16'($urandom_range(1000, 65535)));
      queue_write(CFG_UPPER_LIMIT, 16'($urandom_range(0, 65535)));
      queue_write(CFG_LOWER_LIMIT, 16'($urandom_range(0, 65535)));
      flush_writes();
      center = $urandom_range(1000, 3000);
      case ($urandom_range(0, 2))
        0: spread = 4095;
        1: spread = 300;
        default: spread = 20;
      endcase
      for (int i = 0; i < 115; i++) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        if ($urandom_range(0, 3) == 0)
          send_sample(draw_sample(2048, 4095));
        else
          send_sample(draw_sample(center, spread));
      end
    end
    wait_idle();
    steady = 1'b0;
  endtask

  // A zero target below the count: the next sample completes the run.
  task automatic test_completion();
    queue_write(CFG_SENSING_MODE, 16'($urandom_range(0, 1)));
    case ($urandom_range(0, 2))
      0: begin
        queue_write(CFG_UPPER_LIMIT, 16'd4095);
        queue_write(CFG_LOWER_LIMIT, 16'd0);
      end
      1: begin
        queue_write(CFG_UPPER_LIMIT, 16'd1000);
        queue_write(CFG_LOWER_LIMIT, 16'd3000);
      end
      default: begin
        queue_write(CFG_UPPER_LIMIT, 16'd2248);
        queue_write(CFG_LOWER_LIMIT, 16'd1848);
      end
    endcase
    queue_write(CFG_SAMPLE_TARGET, 16'd0);
    flush_writes();
    repeat (10) send_sample(draw_sample(2048, 4095));
    wait_idle();
  endtask

  // After completion neither samples nor register writes change the result.
  task automatic test_frozen_result();
    queue_write(CFG_SENSING_MODE, {15'd0, ~mode_q});
    queue_write(CFG_SAMPLE_TARGET, 16'd3);
    queue_write(CFG_UPPER_LIMIT, 16'd0);
    queue_write(CFG_LOWER_LIMIT, 16'd4095);
    flush_writes();
    send_sample(pack_sample(12'h000, 12'h000, 12'h000, 12'h000));
    send_sample(pack_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
    repeat (28) send_sample(draw_sample(2048, 4095));
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SENSING_MODE;
    cfg_data_i  <= '0;
    mode_q       = 1'b0;
    target_q     = 16'd1024;
    upper_q      = 12'd2248;
    lower_q      = 12'd1848;
    taken_cnt    = '0;
    acc_a        = '0;
    acc_b        = '0;
    acc_c        = '0;
    acc_shunt    = '0;
    calib_done   = 1'b0;
    held_status  = STATUS_BUSY;
    mismatches   = 0;
    results_seen = 0;
    steady       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_accumulation();
    test_completion();
    test_frozen_result();

    wait_idle();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && offset_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
